>>> design/utcs_pkg.sv
// ----------------------------------------------------------------------------
// utcs_pkg
// Shared constants, types and tables for the seconds to civil date pipeline.
// ----------------------------------------------------------------------------
package utcs_pkg;

  // stage counts of the three pipeline sections
  localparam int unsigned SplitStages = 4;
  localparam int unsigned CivilStages = 10;
  localparam int unsigned TodStages   = 3;
  localparam int unsigned TodAlign    = CivilStages - TodStages;
  localparam int unsigned Latency     = SplitStages + CivilStages;

  // multiple of 86400 that lifts every 36-bit signed time above zero
  localparam logic [36:0] EpochBias      = 37'd34359811200;
  // days from 0000-03-01 to the epoch minus the day bias above
  localparam logic [20:0] ZBias          = 21'd321785;
  localparam logic [20:0] Recip675Q30    = 21'd1590728;
  localparam logic [20:0] DaysPerEra     = 21'd146097;
  localparam logic [17:0] LastDayOfEra   = 18'd146096;
  localparam logic [17:0] DaysPerCentury = 18'd36524;
  localparam logic [7:0]  Recip365Q16    = 8'd179;
  localparam logic [9:0]  Recip365Q18    = 10'd718;
  localparam logic [6:0]  Recip60Q12     = 7'd68;
  localparam logic [16:0] SecsPerHour    = 17'd3600;
  localparam logic [16:0] SecsPerDay     = 17'd86400;

  typedef struct packed {
    logic [20:0] z;    // days since 0000-03-01
    logic [16:0] sod;  // second of the day
  } day_split_t;

  typedef struct packed {
    logic [4:0] hour;
    logic [5:0] minute;
    logic [5:0] second;
  } tod_t;

  // first day of each march-based month within the year
  function automatic logic [8:0] month_start(input logic [3:0] mp);
    logic [8:0] ms;
    case (mp)
      4'd0:    ms = 9'd0;
      4'd1:    ms = 9'd31;
      4'd2:    ms = 9'd61;
      4'd3:    ms = 9'd92;
      4'd4:    ms = 9'd122;
      4'd5:    ms = 9'd153;
      4'd6:    ms = 9'd184;
      4'd7:    ms = 9'd214;
      4'd8:    ms = 9'd245;
      4'd9:    ms = 9'd275;
      4'd10:   ms = 9'd306;
      4'd11:   ms = 9'd337;
      default: ms = 9'd0;
    endcase
    return ms;
  endfunction

endpackage

>>> design/utcs_day_split.sv
// ----------------------------------------------------------------------------
// utcs_day_split
// Floor-divides signed seconds by 86400 into a march-based day count and a
// second of the day, using a biased reciprocal multiply and one correction.
// ----------------------------------------------------------------------------
module utcs_day_split (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  valid_i,
  input  logic signed [35:0]    utc_seconds_i,
  output logic                  valid_o,
  output utcs_pkg::day_split_t  split_o
);
  import utcs_pkg::*;

  logic [SplitStages-1:0] vld_q;

  logic [36:0] u_d;
  logic [29:0] s1_x_q;
  logic [6:0]  s1_r7_q;

  logic [50:0] q_prod_d;
  logic [29:0] s2_x_q;
  logic [20:0] s2_q0_q;
  logic [6:0]  s2_r7_q;

  logic [29:0] r0_full_d;
  logic [10:0] s3_r0_q;
  logic [20:0] s3_q0_q;
  logic [6:0]  s3_r7_q;

  logic        carry_d;
  logic [10:0] rem_d;
  day_split_t  split_d;
  day_split_t  s4_split_q;

  // biased time is nonnegative, so plain division gives the floor
  assign u_d       = {utc_seconds_i[35], utc_seconds_i} + EpochBias;
  assign q_prod_d  = s1_x_q * Recip675Q30;
  assign r0_full_d = s2_x_q - 30'(s2_q0_q) * 30'd675;

  always_comb begin
    carry_d       = (s3_r0_q >= 11'd675);
    rem_d         = carry_d ? (s3_r0_q - 11'd675) : s3_r0_q;
    split_d.sod   = {rem_d[9:0], s3_r7_q};
    split_d.z     = s3_q0_q + (carry_d ? (ZBias + 21'd1) : ZBias);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else begin
      vld_q <= {vld_q[SplitStages-2:0], valid_i};
    end
  end

  always_ff @(posedge clk_i) begin
    s1_x_q     <= u_d[36:7];
    s1_r7_q    <= u_d[6:0];
    s2_x_q     <= s1_x_q;
    s2_q0_q    <= q_prod_d[50:30];
    s2_r7_q    <= s1_r7_q;
    s3_r0_q    <= r0_full_d[10:0];
    s3_q0_q    <= s2_q0_q;
    s3_r7_q    <= s2_r7_q;
    s4_split_q <= split_d;
  end

  assign valid_o = vld_q[SplitStages-1];
  assign split_o = s4_split_q;

  a_sod_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    vld_q[SplitStages-1] |-> (s4_split_q.sod < SecsPerDay) && (s4_split_q.z >= ZBias))
    else $error("day split out of range");

endmodule

>>> design/utcs_tod.sv
// ----------------------------------------------------------------------------
// utcs_tod
// Splits the second of the day into hour, minute and second, then delays the
// result to line up with the date pipeline.
// ----------------------------------------------------------------------------
module utcs_tod (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            valid_i,
  input  logic [16:0]     sod_i,
  output logic            valid_o,
  output utcs_pkg::tod_t  tod_o
);
  import utcs_pkg::*;

  logic [CivilStages-1:0] vld_q;

  logic [4:0]  hour_d;
  logic [16:0] hrem_full_d;
  logic [4:0]  t1_hour_q;
  logic [11:0] t1_rem_q;

  logic [18:0] m_prod_d;
  logic [4:0]  t2_hour_q;
  logic [11:0] t2_rem_q;
  logic [5:0]  t2_m0_q;

  logic [11:0] r_full_d;
  logic [4:0]  t3_hour_q;
  logic [5:0]  t3_m0_q;
  logic [6:0]  t3_r_q;

  logic        mcarry_d;
  tod_t        tod_d;
  tod_t        align_q [TodAlign];

  always_comb begin
    hour_d = '0;
    for (int k = 1; k < 24; k++) begin
      if (sod_i >= 17'(k) * SecsPerHour) begin
        hour_d = 5'(k);
      end
    end
    hrem_full_d = sod_i - 17'(hour_d) * SecsPerHour;
  end

  assign m_prod_d = t1_rem_q * Recip60Q12;
  assign r_full_d = t2_rem_q - 12'(t2_m0_q) * 12'd60;

  always_comb begin
    mcarry_d     = (t3_r_q >= 7'd60);
    tod_d.hour   = t3_hour_q;
    tod_d.minute = t3_m0_q + 6'(mcarry_d);
    tod_d.second = mcarry_d ? 6'(t3_r_q - 7'd60) : t3_r_q[5:0];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else begin
      vld_q <= {vld_q[CivilStages-2:0], valid_i};
    end
  end

  always_ff @(posedge clk_i) begin
    t1_hour_q  <= hour_d;
    t1_rem_q   <= hrem_full_d[11:0];
    t2_hour_q  <= t1_hour_q;
    t2_rem_q   <= t1_rem_q;
    t2_m0_q    <= m_prod_d[17:12];
    t3_hour_q  <= t2_hour_q;
    t3_m0_q    <= t2_m0_q;
    t3_r_q     <= r_full_d[6:0];
    align_q[0] <= tod_d;
    for (int i = 1; i < TodAlign; i++) begin
      align_q[i] <= align_q[i-1];
    end
  end

  assign valid_o = vld_q[CivilStages-1];
  assign tod_o   = align_q[TodAlign-1];

  a_tod_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    vld_q[CivilStages-1] |->
      (tod_o.hour < 5'd24) && (tod_o.minute < 6'd60) && (tod_o.second < 6'd60))
    else $error("time of day out of range");

endmodule

>>> design/utcs_civil.sv
// ----------------------------------------------------------------------------
// utcs_civil
// Turns a march-based day count into year, month and day through era, day of
// era, year of era, day of year and march-based month.
// ----------------------------------------------------------------------------
module utcs_civil (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        valid_i,
  input  logic [20:0] z_i,
  output logic        valid_o,
  output logic [11:0] year_o,
  output logic [3:0]  month_o,
  output logic [4:0]  dom_o
);
  import utcs_pkg::*;

  logic [CivilStages-1:0] vld_q;

  // stage 1: era and day of era
  logic [2:0]  era_d;
  logic [20:0] doe_full_d;
  logic [2:0]  c1_era_q;
  logic [17:0] c1_doe_q;

  // stage 2: doe/1460 estimate, doe/36524, last day of era
  logic [23:0] a_prod_d;
  logic [2:0]  cent_d;
  logic [2:0]  c2_era_q;
  logic [17:0] c2_doe_q;
  logic [6:0]  c2_a0_q;
  logic [2:0]  c2_cent_q;
  logic        c2_last_q;

  // stage 3: remainder of the estimate
  logic [15:0] ra_full_d;
  logic [2:0]  c3_era_q;
  logic [17:0] c3_doe_q;
  logic [6:0]  c3_a0_q;
  logic [2:0]  c3_cent_q;
  logic        c3_last_q;
  logic [9:0]  c3_ra_q;

  // stage 4: leap corrected day count
  logic [6:0]  a_d;
  logic [17:0] n_d;
  logic [2:0]  c4_era_q;
  logic [17:0] c4_doe_q;
  logic [17:0] c4_n_q;

  // stage 5: year of era estimate
  logic [27:0] y_prod_d;
  logic [2:0]  c5_era_q;
  logic [17:0] c5_doe_q;
  logic [17:0] c5_n_q;
  logic [8:0]  c5_y0_q;

  // stage 6: remainder of the estimate
  logic [17:0] ry_full_d;
  logic [2:0]  c6_era_q;
  logic [17:0] c6_doe_q;
  logic [8:0]  c6_y0_q;
  logic [9:0]  c6_ry_q;

  // stage 7: year of era
  logic [2:0]  c7_era_q;
  logic [17:0] c7_doe_q;
  logic [8:0]  c7_yoe_q;

  // stage 8: day of year
  logic [1:0]  centy_d;
  logic [17:0] doy_full_d;
  logic [2:0]  c8_era_q;
  logic [8:0]  c8_yoe_q;
  logic [8:0]  c8_doy_q;

  // stage 9: march-based month
  logic [10:0] t5_d;
  logic [3:0]  mp_d;
  logic [2:0]  c9_era_q;
  logic [8:0]  c9_yoe_q;
  logic [8:0]  c9_doy_q;
  logic [3:0]  c9_mp_q;

  // stage 10: calendar fields
  logic [8:0]  dom_full_d;
  logic [3:0]  mon_d;
  logic [11:0] year_d;
  logic [11:0] year_q;
  logic [3:0]  month_q;
  logic [4:0]  dom_q;

  always_comb begin
    era_d = '0;
    for (int k = 1; k < 8; k++) begin
      if (z_i >= 21'(k) * DaysPerEra) begin
        era_d = 3'(k);
      end
    end
    doe_full_d = z_i - 21'(era_d) * DaysPerEra;
  end

  assign a_prod_d = c1_doe_q[17:2] * Recip365Q16;

  always_comb begin
    cent_d = '0;
    for (int k = 1; k < 5; k++) begin
      if (c1_doe_q >= 18'(k) * DaysPerCentury) begin
        cent_d = 3'(k);
      end
    end
  end

  assign ra_full_d = c2_doe_q[17:2] - 16'(c2_a0_q) * 16'd365;

  always_comb begin
    a_d = c3_a0_q + 7'(c3_ra_q >= 10'd365);
    n_d = c3_doe_q - 18'(a_d) + 18'(c3_cent_q) - 18'(c3_last_q);
  end

  assign y_prod_d  = c4_n_q * Recip365Q18;
  assign ry_full_d = c5_n_q - 18'(c5_y0_q) * 18'd365;

  always_comb begin
    centy_d    = {1'b0, c7_yoe_q >= 9'd100} + {1'b0, c7_yoe_q >= 9'd200}
               + {1'b0, c7_yoe_q >= 9'd300};
    doy_full_d = c7_doe_q - 18'(c7_yoe_q) * 18'd365 - 18'(c7_yoe_q[8:2])
               + 18'(centy_d);
  end

  always_comb begin
    t5_d = 11'(c8_doy_q) * 11'd5 + 11'd2;
    mp_d = '0;
    for (int k = 1; k < 12; k++) begin
      if (t5_d >= 11'(k) * 11'd153) begin
        mp_d = 4'(k);
      end
    end
  end

  always_comb begin
    dom_full_d = c9_doy_q - month_start(c9_mp_q) + 9'd1;
    mon_d      = (c9_mp_q < 4'd10) ? (c9_mp_q + 4'd3) : (c9_mp_q - 4'd9);
    // january and february belong to the next civil year
    year_d     = 12'(c9_era_q) * 12'd400 + 12'(c9_yoe_q) + 12'(c9_mp_q >= 4'd10);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else begin
      vld_q <= {vld_q[CivilStages-2:0], valid_i};
    end
  end

  always_ff @(posedge clk_i) begin
    c1_era_q  <= era_d;
    c1_doe_q  <= doe_full_d[17:0];

    c2_era_q  <= c1_era_q;
    c2_doe_q  <= c1_doe_q;
    c2_a0_q   <= a_prod_d[22:16];
    c2_cent_q <= cent_d;
    c2_last_q <= (c1_doe_q == LastDayOfEra);

    c3_era_q  <= c2_era_q;
    c3_doe_q  <= c2_doe_q;
    c3_a0_q   <= c2_a0_q;
    c3_cent_q <= c2_cent_q;
    c3_last_q <= c2_last_q;
    c3_ra_q   <= ra_full_d[9:0];

    c4_era_q  <= c3_era_q;
    c4_doe_q  <= c3_doe_q;
    c4_n_q    <= n_d;

    c5_era_q  <= c4_era_q;
    c5_doe_q  <= c4_doe_q;
    c5_n_q    <= c4_n_q;
    c5_y0_q   <= y_prod_d[26:18];

    c6_era_q  <= c5_era_q;
    c6_doe_q  <= c5_doe_q;
    c6_y0_q   <= c5_y0_q;
    c6_ry_q   <= ry_full_d[9:0];

    c7_era_q  <= c6_era_q;
    c7_doe_q  <= c6_doe_q;
    c7_yoe_q  <= c6_y0_q + 9'(c6_ry_q >= 10'd365);

    c8_era_q  <= c7_era_q;
    c8_yoe_q  <= c7_yoe_q;
    c8_doy_q  <= doy_full_d[8:0];

    c9_era_q  <= c8_era_q;
    c9_yoe_q  <= c8_yoe_q;
    c9_doy_q  <= c8_doy_q;
    c9_mp_q   <= mp_d;

    year_q    <= year_d;
    month_q   <= mon_d;
    dom_q     <= dom_full_d[4:0];
  end

  assign valid_o = vld_q[CivilStages-1];
  assign year_o  = year_q;
  assign month_o = month_q;
  assign dom_o   = dom_q;

  a_month_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    vld_q[CivilStages-1] |-> (month_q >= 4'd1) && (month_q <= 4'd12) && (dom_q != 5'd0))
    else $error("month or day out of range");

  a_mp_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    vld_q[CivilStages-2] |-> (c9_mp_q <= 4'd11) && (c9_doy_q <= 9'd365))
    else $error("march-based month or day of year out of range");

endmodule

>>> design/utc_seconds_to_civil_datetime.sv
// ----------------------------------------------------------------------------
// utc_seconds_to_civil_datetime
// A request passes the day split stages, then the date and time of day stages side by side.
// Throughput one request per cycle; busy_o stays low, the receiver cannot stall.
// Rate is set by the fourteen-stage pipeline, which spreads the constant divides over its stages.
// Reset clears only the valid bits; no request is in flight after reset.
// ----------------------------------------------------------------------------
module utc_seconds_to_civil_datetime (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               start_i,
  output logic               busy_o,
  input  logic signed [35:0] utc_seconds_i,
  output logic               valid_o,
  output logic [11:0]        year_o,
  output logic [3:0]         month_o,
  output logic [4:0]         day_of_month_o,
  output logic [4:0]         hour_o,
  output logic [5:0]         minute_o,
  output logic [5:0]         second_o
);
  import utcs_pkg::*;

  logic       split_valid;
  day_split_t split;
  logic       tod_valid;
  tod_t       tod;
  logic       date_valid;

  // fully pipelined, never holds a request off
  assign busy_o = 1'b0;

  utcs_day_split u_split (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .valid_i       (start_i),
    .utc_seconds_i (utc_seconds_i),
    .valid_o       (split_valid),
    .split_o       (split)
  );

  utcs_tod u_tod (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (split_valid),
    .sod_i   (split.sod),
    .valid_o (tod_valid),
    .tod_o   (tod)
  );

  utcs_civil u_civil (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (split_valid),
    .z_i     (split.z),
    .valid_o (date_valid),
    .year_o  (year_o),
    .month_o (month_o),
    .dom_o   (day_of_month_o)
  );

  assign valid_o  = date_valid;
  assign hour_o   = tod.hour;
  assign minute_o = tod.minute;
  assign second_o = tod.second;

  a_paths_aligned: assert property (@(posedge clk_i) disable iff (!rst_ni)
    tod_valid == date_valid)
    else $error("time and date paths out of step");

  a_latency: assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_o |-> $past(start_i, Latency))
    else $error("result without a matching request");

endmodule
